// File: rtl/sde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_pkg
// shared types and codes of the synthetic division evaluator
// ----------------------------------------------------------------------------
package sde_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 4;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // configuration register index (byte address bit 2)
  localparam logic REG_DEGREE = 1'b0;

  typedef struct packed {
    logic                    cmd;
    logic [IdxW-1:0]         coef_index;
    logic signed [DataW-1:0] coef_value;
    logic signed [DataW-1:0] point_value;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]         power_index;
    logic signed [DataW-1:0] product_term;
    logic signed [DataW-1:0] running_value;
    logic                    last;
  } out_item_t;

endpackage

// File: rtl/synthetic_division_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synthetic_division_evaluator_unit
// polynomial evaluation by ruffini's rule over a coefficient ram
// ----------------------------------------------------------------------------
//
//  port group | direction | handshake            | payload
//  -----------+-----------+----------------------+---------------------------
//  in         | in        | in_valid_i/in_stall_o | in_item_t (load/evaluate)
//  out        | out       | out_valid_o/out_stall_i | out_item_t (one row)
//  apb        | in        | psel/penable/pready  | degree register at 0x0
//
//  a load transaction writes the ram directly
//  an evaluate transaction first issues the ram read of the top power, then
//  yields one row per cycle while the output does not stall, set by the
//  single ram read port and the one multiply-add feeding the next row
//  input is stalled while an evaluation runs; output stalls freeze the walk
//  reset clears control state and degree; the ram has no reset, every power
//  up to degree must be loaded before an evaluate
//
module synthetic_division_evaluator_unit
  import sde_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  // row output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW  = $clog2(MAX_TERMS);
  // highest power the ram holds, limited to what the index field can name
  localparam int unsigned TopCap = (MAX_TERMS - 1 > 15) ? 15 : MAX_TERMS - 1;

  logic [IdxW-1:0]  degree;
  logic [IdxW-1:0]  top;
  logic             in_accept;
  logic             load_we;
  logic             start;
  logic             busy;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [DataW-1:0] ram_rdata;
  logic             row_valid;
  out_item_t        row;
  logic             out_ready;
  logic             out_valid_d, out_valid_q;
  out_item_t        out_data_d, out_data_q;

  sde_apb_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .degree_o (degree)
  );

  // degree saturates at the top of the store
  assign top = (degree > IdxW'(TopCap)) ? IdxW'(TopCap) : degree;

  // one transaction at a time: input waits while a walk runs
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i & ~busy;
  assign start      = in_accept & (in_data_i.cmd == CMD_EVAL);
  // loads beyond the store are dropped
  assign load_we    = in_accept & (in_data_i.cmd == CMD_LOAD)
                    & (32'(in_data_i.coef_index) < MAX_TERMS);

  sde_ram #(
    .WIDTH (DataW),
    .DEPTH (MAX_TERMS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AddrW'(in_data_i.coef_index)),
    .wdata_i (in_data_i.coef_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sde_horner_seq #(
    .MAX_TERMS (MAX_TERMS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .top_i       (top),
    .point_i     (in_data_i.point_value),
    .out_ready_i (out_ready),
    .coef_i      (ram_rdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .busy_o      (busy),
    .row_valid_o (row_valid),
    .row_o       (row)
  );

  // output register: takes a new row when empty or when its row leaves
  assign out_ready = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_ready) begin
      out_valid_d = row_valid;
      if (row_valid) begin
        out_data_d = row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/sde_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sde_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_apb_regs
// apb register file holding the polynomial degree
// ----------------------------------------------------------------------------
module sde_apb_regs
  import sde_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [IdxW-1:0] degree_o
);

  logic [IdxW-1:0] degree_d, degree_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    degree_d = degree_q;
    if (wr_en && paddr[2] == REG_DEGREE) begin
      degree_d = pwdata[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
    end else begin
      degree_q <= degree_d;
    end
  end

  assign prdata   = (paddr[2] == REG_DEGREE) ? {{(32-IdxW){1'b0}}, degree_q} : '0;
  assign degree_o = degree_q;

endmodule

// File: rtl/sde_horner_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_horner_seq
// walks the coefficient ram from the top power down, one multiply-add a row
// ----------------------------------------------------------------------------
module sde_horner_seq
  import sde_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [IdxW-1:0]              top_i,
  input  logic [DataW-1:0]             point_i,
  input  logic                         out_ready_i,
  input  logic [DataW-1:0]             coef_i,
  output logic                         ram_re_o,
  output logic [$clog2(MAX_TERMS)-1:0] ram_raddr_o,
  output logic                         busy_o,
  output logic                         row_valid_o,
  output out_item_t                    row_o
);

  localparam int unsigned AddrW = $clog2(MAX_TERMS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e           state_d, state_q;
  logic [IdxW-1:0]  pow_d, pow_q;
  logic             first_d, first_q;
  logic [DataW-1:0] point_d, point_q;
  logic [DataW-1:0] prev_d, prev_q;
  logic [DataW-1:0] prod_w;
  logic [DataW-1:0] term_w;
  logic             fire;

  // low word of the product, wraps like the arithmetic it models
  assign prod_w = DataW'(point_q * prev_q);
  assign term_w = first_q ? '0 : prod_w;

  always_comb begin
    row_o.power_index   = pow_q;
    row_o.product_term  = term_w;
    row_o.running_value = coef_i + term_w;
    row_o.last          = (pow_q == '0);
  end

  assign row_valid_o = (state_q == ST_RUN);
  assign fire        = row_valid_o & out_ready_i;
  assign busy_o      = (state_q != ST_IDLE);

  // next read is issued only as the current row leaves, so ram data holds on stall
  assign ram_re_o    = start_i | (fire & ~row_o.last);
  assign ram_raddr_o = start_i ? AddrW'(top_i) : AddrW'(pow_q - 1'b1);

  always_comb begin
    state_d = state_q;
    pow_d   = pow_q;
    first_d = first_q;
    point_d = point_q;
    prev_d  = prev_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          pow_d   = top_i;
          first_d = 1'b1;
          point_d = point_i;
        end
      end
      ST_RUN: begin
        if (fire) begin
          prev_d  = row_o.running_value;
          first_d = 1'b0;
          pow_d   = pow_q - 1'b1;
          if (row_o.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
      pow_q   <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      pow_q   <= pow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    point_q <= point_d;
    prev_q  <= prev_d;
  end

endmodule

// File: tb/sde_horner_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_horner_checker
// mirrors the coefficient store and degree register, predicts the rows of
// every evaluate transaction by horner's scheme and compares them in order
// ----------------------------------------------------------------------------
module sde_horner_checker
  import sde_pkg::*;
#(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int unsigned rows_pending_o,
  output int unsigned fail_count_o
);

  logic [DataW-1:0] coef_mirror [MAX_TERMS];
  logic [IdxW-1:0]  degree_mirror;
  out_item_t        horner_rows_q [$];
  int unsigned      fail_count;

  // one row per power, leading coefficient first, wrapping 32-bit arithmetic
  task automatic push_horner_rows(input logic [DataW-1:0] point);
    logic [DataW-1:0] prev;
    logic [DataW-1:0] prod;
    logic [DataW-1:0] run;
    out_item_t        row;
    int               top_power;
    top_power = (degree_mirror > MAX_TERMS - 1) ? MAX_TERMS - 1 : degree_mirror;
    prev = '0;
    for (int p = top_power; p >= 0; p--) begin
      if (p == top_power) begin
        prod = '0;
        run  = coef_mirror[p];
      end else begin
        prod = point * prev;
        run  = coef_mirror[p] + prod;
      end
      row.power_index   = IdxW'(p);
      row.product_term  = prod;
      row.running_value = run;
      row.last          = (p == 0);
      horner_rows_q.push_back(row);
      prev = run;
    end
  endtask

  task automatic check_row(input out_item_t got);
    out_item_t want;
    if (horner_rows_q.size() == 0) begin
      $error("row at power %0d with no row predicted", got.power_index);
      fail_count++;
      return;
    end
    want = horner_rows_q.pop_front();
    if (got.power_index !== want.power_index) begin
      $error("power_index: expected %0d, got %0d", want.power_index, got.power_index);
      fail_count++;
    end
    if (got.product_term !== want.product_term) begin
      $error("product_term: expected %0d, got %0d", want.product_term, got.product_term);
      fail_count++;
    end
    if (got.running_value !== want.running_value) begin
      $error("running_value: expected %0d, got %0d", want.running_value,
             got.running_value);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TERMS; i++) coef_mirror[i] = '0;
      degree_mirror = '0;
      horner_rows_q.delete();
      fail_count = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == REG_DEGREE) begin
        degree_mirror = pwdata_i[IdxW-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        check_row(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.cmd == CMD_LOAD) begin
          if (in_data_i.coef_index < MAX_TERMS) begin
            coef_mirror[in_data_i.coef_index] = in_data_i.coef_value;
          end
        end else begin
          push_horner_rows(in_data_i.point_value);
        end
      end
    end
    rows_pending_o <= horner_rows_q.size();
    fail_count_o   <= fail_count;
  end

endmodule

// File: tb/synthetic_division_evaluator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synthetic_division_evaluator_unit_tb
// loads coefficients and evaluates polynomials at directed and random points
// over several degree settings, with random gaps on the input and random
// stalls on the output; a separate checker predicts every row
// ----------------------------------------------------------------------------
module synthetic_division_evaluator_unit_tb;
  import sde_pkg::*;

  localparam int unsigned MaxTerms   = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SegItems   = 26;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned rows_pending;
  int unsigned fail_count;
  int unsigned cycle_cnt;

  // idling odds in percent, changed per phase
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 61;

  synthetic_division_evaluator_unit #(
    .MAX_TERMS(MaxTerms)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  sde_horner_checker #(
    .MAX_TERMS(MaxTerms)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .rows_pending_o(rows_pending),
    .fail_count_o  (fail_count)
  );

  always #10 clk_i = ~clk_i;

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog: a hang or a lost row ends here
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // a load writes one coefficient; the point field is don't-care, so randomise it
  function automatic in_item_t load_item(input logic [IdxW-1:0] idx,
                                         input logic [DataW-1:0] value);
    in_item_t item;
    item.cmd         = CMD_LOAD;
    item.coef_index  = idx;
    item.coef_value  = value;
    item.point_value = $urandom;
    return item;
  endfunction

  // an evaluate ignores the coefficient fields, so fill them with noise
  function automatic in_item_t eval_item(input logic [DataW-1:0] point);
    in_item_t item;
    item.cmd         = CMD_EVAL;
    item.coef_index  = IdxW'($urandom_range(MaxTerms - 1));
    item.coef_value  = $urandom;
    item.point_value = point;
    return item;
  endfunction

  // present one transaction, with a random gap in front of it; valid stays
  // high between back-to-back transactions and the payload holds while stalled
  task automatic send_item(input in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop sending and wait until every predicted row has been seen; the
  // pending count is registered, hence the edge before the first look.
  // the extra wait lets a trailing load retire before any register write
  task automatic drain;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rows_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write of the degree register: setup cycle, then access until pready
  task automatic write_degree(input logic [IdxW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DEGREE, 2'b00};
    pwdata  <= {{(32 - IdxW){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [DataW-1:0] value;
    logic [DataW-1:0] point;
    logic [IdxW-1:0]  seg_degree;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // every power is loaded first, so no evaluate ever reads an unwritten
    // entry of the store; the value extremes sit at the low powers
    for (int i = 0; i < MaxTerms; i++) begin
      case (i)
        0:       value = 32'h7FFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = 32'hFFFF_FFFF;
        3:       value = 32'h0000_0001;
        4:       value = 32'h0000_0000;
        default: value = $urandom;
      endcase
      send_item(load_item(IdxW'(i), value));
    end

    // degree zero straight after reset: a single remainder row
    send_item(eval_item(32'd5));

    // full degree at the interesting points, including the most negative
    // and most positive ones where the products wrap
    drain();
    write_degree(IdxW'(MaxTerms - 1));
    send_item(eval_item(32'h0000_0000));
    send_item(eval_item(32'h0000_0001));
    send_item(eval_item(32'hFFFF_FFFF));
    send_item(eval_item(32'h8000_0000));
    send_item(eval_item(32'h7FFF_FFFF));

    // degree one: leading row then remainder
    drain();
    write_degree(IdxW'(1));
    send_item(eval_item(32'd2));

    // ---- random part ----
    // three idling phases, each with two degree settings; loads and
    // evaluates are mixed so coefficients change between evaluates
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        case (phase * 2 + seg)
          0:       seg_degree = IdxW'(MaxTerms - 1);
          1:       seg_degree = '0;
          default: seg_degree = IdxW'($urandom_range(MaxTerms - 1));
        endcase
        // register writes only once every predicted row has arrived
        drain();
        write_degree(seg_degree);
        for (int n = 0; n < SegItems; n++) begin
          if ($urandom_range(1) == 0) begin
            send_item(load_item(IdxW'($urandom_range(MaxTerms - 1)), $urandom));
          end else begin
            // small points keep the values readable, full-range ones wrap
            point = ($urandom_range(3) == 0) ? 32'($urandom_range(6)) - 32'd3 : $urandom;
            send_item(eval_item(point));
          end
        end
      end
    end

    // let the last rows come out, then a short settling tail
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rows_pending != 0);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
